// ===== hdl/gbbc_pkg.sv =====
package gbbc_pkg;

  localparam int unsigned HourW = 12;
  localparam int unsigned CntW  = 5;

  typedef struct packed {
    logic [11:0] earliest_hour;
    logic [11:0] latest_hour;
    logic        final_offer;
  } in_item_t;

  typedef struct packed {
    logic [3:0]  group_ordinal;
    logic [3:0]  offer_index;
    logic [11:0] box_min_earliest;
    logic [11:0] box_max_earliest;
    logic [11:0] box_min_latest;
    logic [11:0] box_max_latest;
    logic [4:0]  members_in_group;
    logic        group_end;
    logic        last_result;
    logic        overflow_flag;
  } out_item_t;

  localparam logic [1:0] CfgEstSpan   = 2'd0;
  localparam logic [1:0] CfgLstSpan   = 2'd1;
  localparam logic [1:0] CfgGroupSize = 2'd2;

  // controller to datapath
  typedef struct packed {
    logic load;        // store incoming offer
    logic scan_init;   // reset pair scan
    logic scan_step;   // evaluate one pair
    logic merge_init;  // capture merged group, link member lists
    logic merge_step;  // move one group down, or place merged group
    logic emit_init;   // start output walk
    logic emit_step;   // advance output walk
    logic clear;       // end of set
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic scan_done;   // all pairs seen
    logic single;      // at most one group
    logic accept;      // best pair merges
    logic merge_last;  // merged group goes in this cycle
    logic emit_last;   // current output is the last
  } dp_sts_t;

endpackage

// ===== hdl/gbbc_datapath.sv =====
module gbbc_datapath
  import gbbc_pkg::*;
#(
  parameter int unsigned MaxOffers = 16
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  dp_cmd_t       cmd_i,
  output dp_sts_t       sts_o,
  input  in_item_t      in_i,
  input  logic [11:0]   est_lim_i,
  input  logic [11:0]   lst_lim_i,
  input  logic [4:0]    size_lim_i,
  output out_item_t     out_o
);
  localparam int unsigned HourBits = HourW;
  localparam int unsigned IdxW = $clog2(MaxOffers);
  localparam int unsigned NW   = IdxW + 1;
  localparam int unsigned SumW = HourBits + 1;
  localparam int unsigned SqW  = 2 * SumW;
  localparam int unsigned DW   = SqW + 1;

  typedef struct packed {
    logic [HourBits-1:0] mn_e, mx_e, mn_l, mx_l;
  } box_t;

  box_t            box_q [MaxOffers];
  logic [NW-1:0]   cnt_q [MaxOffers];
  // member lists as linked offers: first, last and next offer
  logic [IdxW-1:0] head_q [MaxOffers];
  logic [IdxW-1:0] tail_q [MaxOffers];
  logic [IdxW-1:0] nxt_q [MaxOffers];
  logic [NW-1:0]   gtot_q, nload_q;
  logic            drop_q;
  logic [IdxW-1:0] si_q, sj_q, bi_q, bj_q;
  logic [DW-1:0]   best_q;
  logic            found_q, sdone_q;
  logic [IdxW-1:0] cp_q, mhead_q, mtail_q;
  box_t            mbox_q;
  logic [NW-1:0]   mcnt_q;
  logic [NW-1:0]   eg_q, et_q, er_q;
  logic [IdxW-1:0] cur_q;

  // distance of current pair
  logic [SumW-1:0] ci_e, cj_e, ci_l, cj_l, dx, dy;
  logic [DW-1:0]   pair_gap;
  always_comb begin
    ci_e = SumW'(box_q[si_q].mn_e) + SumW'(box_q[si_q].mx_e);
    cj_e = SumW'(box_q[sj_q].mn_e) + SumW'(box_q[sj_q].mx_e);
    ci_l = SumW'(box_q[si_q].mn_l) + SumW'(box_q[si_q].mx_l);
    cj_l = SumW'(box_q[sj_q].mn_l) + SumW'(box_q[sj_q].mx_l);
    dx   = (ci_e > cj_e) ? ci_e - cj_e : cj_e - ci_e;
    dy   = (ci_l > cj_l) ? ci_l - cj_l : cj_l - ci_l;
    pair_gap = DW'(dx * dx) + DW'(dy * dy);
  end

  // merged candidate
  box_t          mbox;
  logic [NW:0]   mcnt;
  logic          acc;
  always_comb begin
    mbox.mn_e = (box_q[bi_q].mn_e < box_q[bj_q].mn_e) ? box_q[bi_q].mn_e : box_q[bj_q].mn_e;
    mbox.mx_e = (box_q[bi_q].mx_e > box_q[bj_q].mx_e) ? box_q[bi_q].mx_e : box_q[bj_q].mx_e;
    mbox.mn_l = (box_q[bi_q].mn_l < box_q[bj_q].mn_l) ? box_q[bi_q].mn_l : box_q[bj_q].mn_l;
    mbox.mx_l = (box_q[bi_q].mx_l > box_q[bj_q].mx_l) ? box_q[bi_q].mx_l : box_q[bj_q].mx_l;
    mcnt = (NW+1)'(cnt_q[bi_q]) + (NW+1)'(cnt_q[bj_q]);
    acc  = (17'(mbox.mx_e - mbox.mn_e) <= 17'(est_lim_i))
        && (17'(mbox.mx_l - mbox.mn_l) <= 17'(lst_lim_i))
        && (7'(mcnt) <= 7'(size_lim_i));
  end

  // compaction: slot cp takes the next group that is neither bi nor bj
  logic [IdxW-1:0] src;
  logic            mlast;
  always_comb begin
    src   = cp_q + ((NW'(cp_q) + NW'(1) < NW'(bj_q)) ? IdxW'(1) : IdxW'(2));
    mlast = (NW'(cp_q) + NW'(2) == gtot_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gtot_q  <= '0;
      nload_q <= '0;
      drop_q  <= 1'b0;
      found_q <= 1'b0;
      sdone_q <= 1'b0;
      for (int k = 0; k < MaxOffers; k++) cnt_q[k] <= '0;
    end else begin
      if (cmd_i.load) begin
        if (nload_q < NW'(MaxOffers)) begin
          box_q[IdxW'(nload_q)] <= '{in_i.earliest_hour[HourBits-1:0],
                                     in_i.earliest_hour[HourBits-1:0],
                                     in_i.latest_hour[HourBits-1:0],
                                     in_i.latest_hour[HourBits-1:0]};
          cnt_q[IdxW'(nload_q)]  <= NW'(1);
          head_q[IdxW'(nload_q)] <= IdxW'(nload_q);
          tail_q[IdxW'(nload_q)] <= IdxW'(nload_q);
          nload_q <= nload_q + NW'(1);
          gtot_q  <= nload_q + NW'(1);
        end else begin
          drop_q <= 1'b1;
        end
      end
      if (cmd_i.scan_init) begin
        si_q <= '0; sj_q <= IdxW'(1); found_q <= 1'b0;
        sdone_q <= (gtot_q < NW'(2));
      end
      if (cmd_i.scan_step) begin
        if (!found_q || pair_gap < best_q) begin
          best_q <= pair_gap; bi_q <= si_q; bj_q <= sj_q; found_q <= 1'b1;
        end
        if (NW'(sj_q) + NW'(1) < gtot_q) begin
          sj_q <= sj_q + IdxW'(1);
        end else if (NW'(si_q) + NW'(2) < gtot_q) begin
          si_q <= si_q + IdxW'(1);
          sj_q <= si_q + IdxW'(2);
        end else begin
          sdone_q <= 1'b1;
        end
      end
      if (cmd_i.merge_init) begin
        mbox_q  <= mbox;
        mcnt_q  <= NW'(mcnt);
        mhead_q <= head_q[bi_q];
        mtail_q <= tail_q[bj_q];
        // members of bi, then members of bj
        nxt_q[tail_q[bi_q]] <= head_q[bj_q];
        cp_q <= bi_q;
      end
      if (cmd_i.merge_step) begin
        if (mlast) begin
          box_q[cp_q]  <= mbox_q;
          cnt_q[cp_q]  <= mcnt_q;
          head_q[cp_q] <= mhead_q;
          tail_q[cp_q] <= mtail_q;
          cnt_q[IdxW'(NW'(cp_q) + NW'(1))] <= '0;
          gtot_q <= gtot_q - NW'(1);
        end else begin
          box_q[cp_q]  <= box_q[src];
          cnt_q[cp_q]  <= cnt_q[src];
          head_q[cp_q] <= head_q[src];
          tail_q[cp_q] <= tail_q[src];
          cp_q <= cp_q + IdxW'(1);
        end
      end
      if (cmd_i.emit_init) begin
        eg_q <= '0; et_q <= '0; er_q <= '0;
        cur_q <= head_q[0];
      end
      if (cmd_i.emit_step) begin
        er_q <= er_q + NW'(1);
        if (et_q + NW'(1) == cnt_q[IdxW'(eg_q)]) begin
          et_q <= '0; eg_q <= eg_q + NW'(1);
          cur_q <= head_q[IdxW'(eg_q + NW'(1))];
        end else begin
          et_q <= et_q + NW'(1);
          cur_q <= nxt_q[cur_q];
        end
      end
      if (cmd_i.clear) begin
        gtot_q <= '0; nload_q <= '0; drop_q <= 1'b0;
        for (int k = 0; k < MaxOffers; k++) cnt_q[k] <= '0;
      end
    end
  end

  always_comb begin
    out_o.group_ordinal    = 4'(eg_q);
    out_o.offer_index      = 4'(cur_q);
    out_o.box_min_earliest = 12'(box_q[IdxW'(eg_q)].mn_e);
    out_o.box_max_earliest = 12'(box_q[IdxW'(eg_q)].mx_e);
    out_o.box_min_latest   = 12'(box_q[IdxW'(eg_q)].mn_l);
    out_o.box_max_latest   = 12'(box_q[IdxW'(eg_q)].mx_l);
    out_o.members_in_group = 5'(cnt_q[IdxW'(eg_q)]);
    out_o.group_end        = (et_q + NW'(1) == cnt_q[IdxW'(eg_q)]);
    out_o.last_result      = (er_q + NW'(1) == nload_q);
    out_o.overflow_flag    = drop_q;
    sts_o.scan_done  = sdone_q;
    sts_o.single     = (gtot_q < NW'(2));
    sts_o.accept     = acc;
    sts_o.merge_last = mlast;
    sts_o.emit_last  = (er_q + NW'(1) >= nload_q);
  end

  a_gtot_le_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    gtot_q <= nload_q) else $error("group total above offers loaded");
  a_merge_shrinks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.merge_step && mlast) |=> gtot_q == $past(gtot_q) - NW'(1))
    else $error("merge count");
  a_pair_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (found_q && cmd_i.merge_init) |-> bi_q < bj_q) else $error("pair order");
endmodule

// ===== hdl/gbbc_ctrl.sv =====
module gbbc_ctrl
  import gbbc_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_ready_o,
  input  logic    in_final_i,
  output logic    out_valid_o,
  input  logic    out_ready_i,
  input  dp_sts_t sts_i,
  output dp_cmd_t cmd_o
);
  typedef enum logic [5:0] {
    SLoad  = 6'b000001,
    SInit  = 6'b000010,
    SScan  = 6'b000100,
    SDec   = 6'b001000,
    SMerge = 6'b010000,
    SEmit  = 6'b100000
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    unique case (state_q)
      SLoad: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          if (in_final_i) state_d = SInit;
        end
      end
      SInit: begin
        cmd_o.scan_init = 1'b1;
        state_d = SScan;
      end
      SScan: begin
        if (sts_i.scan_done) state_d = SDec;
        else cmd_o.scan_step = 1'b1;
      end
      SDec: begin
        if (!sts_i.single && sts_i.accept) begin
          cmd_o.merge_init = 1'b1;
          state_d = SMerge;
        end else begin
          cmd_o.emit_init = 1'b1;
          state_d = SEmit;
        end
      end
      SMerge: begin
        cmd_o.merge_step = 1'b1;
        if (sts_i.merge_last) state_d = SInit;
      end
      SEmit: begin
        out_valid_o = 1'b1;
        if (out_ready_i) begin
          cmd_o.emit_step = 1'b1;
          if (sts_i.emit_last) begin
            cmd_o.clear = 1'b1;
            state_d = SLoad;
          end
        end
      end
      default: state_d = SLoad;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= SLoad;
    else state_q <= state_d;
  end

  a_no_both: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_ready_o && out_valid_o)) else $error("load and emit overlap");
  a_merge_rescan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.merge_step && sts_i.merge_last) |=> state_q == SInit)
    else $error("no rescan after merge");
  a_final_go: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o && in_final_i) |=> !in_ready_o) else $error("final ignored");
endmodule

// ===== hdl/greedy_bounding_box_clustering_unit.sv =====
// channel | dir | handshake           | payload
// in      | in  | in_valid/in_ready   | in_item_t
// out     | out | out_valid/out_ready | out_item_t
// cfg     | in  | cfg_valid/cfg_ready | cfg_index, cfg_data
// one offer per cycle while loading; non-final offers give no result
// a final offer runs up to n-1 merge rounds for n stored offers; a round is a setup
//   step, a scan of every pair of groups, a scan end and a decision, and a merge
//   compacts the groups from the lower pair index to the end of the list
// results then leave one per transfer, stalled by out_ready
// reset clears counts and the controller; stores are written before read
module greedy_bounding_box_clustering_unit
  import gbbc_pkg::*;
#(
  parameter int unsigned MAX_OFFERS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  in_item_t    in_data_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output out_item_t   out_data_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [11:0] cfg_data_i
);
  logic [11:0] est_q, lst_q;
  logic [4:0]  size_q;
  dp_cmd_t     cmd;
  dp_sts_t     sts;

  // registers take a transfer at any time
  assign cfg_ready_o = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      est_q  <= 12'd4;
      lst_q  <= 12'd4;
      size_q <= 5'd16;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CfgEstSpan:   est_q  <= cfg_data_i;
        CfgLstSpan:   lst_q  <= cfg_data_i;
        CfgGroupSize: size_q <= cfg_data_i[4:0];
        default: ;
      endcase
    end
  end

  gbbc_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .in_valid_i, .in_ready_o,
    .in_final_i (in_data_i.final_offer),
    .out_valid_o, .out_ready_i,
    .sts_i (sts), .cmd_o (cmd)
  );

  gbbc_datapath #(.MaxOffers(MAX_OFFERS)) u_dp (
    .clk_i, .rst_ni,
    .cmd_i (cmd), .sts_o (sts),
    .in_i (in_data_i),
    .est_lim_i (est_q), .lst_lim_i (lst_q), .size_lim_i (size_q),
    .out_o (out_data_o)
  );
endmodule
